// ----- rtl/core/fpmdc_pkg.sv -----
// Shared constants, opcodes, control structs and helpers for the 16.16 fixed-point unit
`timescale 1ns / 1ps
`default_nettype none

package fpmdc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int QUO_W     = WORD_W + FRAC_BITS;
    localparam int MAG_W     = 2 * WORD_W;
    localparam int CNT_W     = $clog2(QUO_W);

    // single-precision float fields
    localparam int FLT_EXP_W  = 8;
    localparam int FLT_MANT_W = 23;
    localparam logic [FLT_EXP_W-1:0] FLT_EXP_SPECIAL = 8'hff;
    localparam logic [FLT_EXP_W-1:0] FLT_EXP_ZERO    = 8'h00;
    // shift = exp - 127 - 23 + FRAC_BITS
    localparam int CVT_BIAS      = 127 + FLT_MANT_W - FRAC_BITS;
    localparam int CVT_MAX_SHIFT = 40;
    localparam int CVT_MIN_SHIFT = -(FLT_MANT_W + 1);

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_CVT  = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } fpmdc_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } fpmdc_stat_t;

    function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? (~v + {{(WORD_W-1){1'b0}}, 1'b1}) : v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/fpmdc_if.sv -----
// Valid/ready channel interfaces for requests and results
`timescale 1ns / 1ps
`default_nettype none

interface fpmdc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, output req_type, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input req_type, input operand_a, input operand_b,
                    output ready);
endinterface

interface fpmdc_rsp_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] result;
    logic        overflow;
    logic        div_by_zero;

    modport source (output valid, output result, output overflow, output div_by_zero,
                    input ready);
    modport sink   (input valid, input result, input overflow, input div_by_zero,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/fpmdc_iter_unit.sv -----
// Shared add/subtract unit: shift-add multiply and restoring divide, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module fpmdc_iter_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fpmdc_pkg::fpmdc_cmd_t          cmd,
    input  logic [fpmdc_pkg::WORD_W-1:0]   mag_a,
    input  logic [fpmdc_pkg::WORD_W-1:0]   mag_b,
    output fpmdc_pkg::fpmdc_stat_t         stat,
    output logic [fpmdc_pkg::MAG_W-1:0]    mag
);
    import fpmdc_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic             is_div_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]  lo_reg, lo_next;
    logic [WORD_W-1:0] opd_reg;

    logic [WORD_W:0]   add_a, add_b;
    logic [WORD_W+1:0] sum;
    logic              q_bit;

    // one 34-bit adder serves both operations
    always_comb
    begin
        q_bit = 1'b0;
        if (is_div_reg)
        begin
            add_a    = {rem_reg, lo_reg[QUO_W-1]};
            add_b    = {1'b0, opd_reg};
            sum      = {1'b0, add_a} + {1'b1, ~add_b} + {{(WORD_W+1){1'b0}}, 1'b1};
            q_bit    = ~sum[WORD_W+1];
            rem_next = q_bit ? sum[WORD_W-1:0] : add_a[WORD_W-1:0];
            lo_next  = {lo_reg[QUO_W-2:0], q_bit};
        end
        else
        begin
            add_a    = {1'b0, rem_reg};
            add_b    = lo_reg[0] ? {1'b0, opd_reg} : '0;
            sum      = {1'b0, add_a} + {1'b0, add_b};
            rem_next = sum[WORD_W:1];
            lo_next  = {lo_reg[QUO_W-1:WORD_W], sum[0], lo_reg[WORD_W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            is_div_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg   <= 1'b1;
                is_div_reg <= cmd.is_div;
                cnt_reg    <= cmd.is_div ? CNT_W'(QUO_W - 1) : CNT_W'(WORD_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg <= '0;
            opd_reg <= mag_b;
            lo_reg  <= cmd.is_div ? {mag_a, {FRAC_BITS{1'b0}}} : {{FRAC_BITS{1'b0}}, mag_a};
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            lo_reg  <= lo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    // divide: quotient; multiply: product shifted right by the fraction width
    assign mag = is_div_reg ? {{(MAG_W-QUO_W){1'b0}}, lo_reg}
                            : {{FRAC_BITS{1'b0}}, rem_reg, lo_reg[WORD_W-1:FRAC_BITS]};

endmodule

`default_nettype wire

// ----- rtl/core/fixed_point_mul_div_convert.sv -----
// Top level of the 16.16 fixed-point multiply / divide / float-convert unit.
// Multiply and nonzero divide: S_IDLE accepts, the shared unit iterates in S_RUN, S_FIN registers the result.
// Divide works out 48 quotient bits through the shared adder; a new item waits for S_IDLE and an idle unit.
// Convert, divide by zero, unused opcode: S_IDLE accepts, then S_FIN registers the result.
// The result register lets a new item in while the previous result waits to be taken.
// Reset (rst_n low, asynchronous) drops any item in flight and clears the result valid.
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_mul_div_convert (
    input  logic       clk,
    input  logic       rst_n,
    fpmdc_req_if.sink  req,
    fpmdc_rsp_if.source rsp
);
    import fpmdc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } state_t;

    localparam logic signed [9:0] SH_MAX  = 10'(CVT_MAX_SHIFT);
    localparam logic signed [9:0] SH_MIN  = 10'(CVT_MIN_SHIFT);
    localparam logic signed [9:0] SH_BIAS = 10'(CVT_BIAS);

    state_t            state_reg;
    op_t               op_reg;
    logic [WORD_W-1:0] a_reg;
    logic              neg_reg;
    logic              dz_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] result_reg;
    logic              ovf_reg;
    logic              dz_out_reg;

    logic              accept;
    op_t               op_in;
    logic              b_zero;
    fpmdc_cmd_t        cmd;
    fpmdc_stat_t       stat;
    logic [MAG_W-1:0]  unit_mag;

    logic [FLT_EXP_W-1:0]  cvt_exp;
    logic [FLT_MANT_W:0]   cvt_mant;
    logic signed [9:0]     cvt_sh;
    logic [MAG_W-1:0]      cvt_mag;

    logic [MAG_W-1:0]  fin_mag;
    logic              fin_neg;
    logic              sgn_ovf;
    logic [WORD_W-1:0] sgn_res;
    logic [WORD_W-1:0] fin_res;
    logic              fin_ovf;
    logic              fin_dz;

    // take an item only while the sequencer is free
    assign req.ready = (state_reg == S_IDLE) && !stat.busy;
    assign accept    = req.valid && req.ready;
    assign op_in     = op_t'(req.req_type);
    assign b_zero    = (req.operand_b == '0);

    // multiply and nonzero divide go through the shared unit
    assign cmd.start  = accept && ((op_in == OP_MUL) || ((op_in == OP_DIV) && !b_zero));
    assign cmd.is_div = (op_in == OP_DIV);

    fpmdc_iter_unit u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .mag_a (mag32(req.operand_a)),
        .mag_b (mag32(req.operand_b)),
        .stat  (stat),
        .mag   (unit_mag)
    );

    // float to fixed: shift the mantissa with its hidden bit into place
    assign cvt_exp  = a_reg[WORD_W-2:FLT_MANT_W];
    assign cvt_mant = {1'b1, a_reg[FLT_MANT_W-1:0]};
    assign cvt_sh   = $signed({2'b00, cvt_exp}) - SH_BIAS;

    always_comb
    begin
        if (cvt_sh < 10'sd0)
            cvt_mag = {{(MAG_W-FLT_MANT_W-1){1'b0}}, cvt_mant >> 5'(-cvt_sh)};
        else
            cvt_mag = {{(MAG_W-FLT_MANT_W-1){1'b0}}, cvt_mant} << 6'(cvt_sh);
    end

    // apply sign, flag magnitudes outside the signed 32-bit range
    assign fin_mag = (op_reg == OP_CVT) ? cvt_mag : unit_mag;
    assign fin_neg = (op_reg == OP_CVT) ? a_reg[WORD_W-1] : neg_reg;
    assign sgn_ovf = fin_neg
        ? ((|fin_mag[MAG_W-1:WORD_W]) || (fin_mag[WORD_W-1] && (|fin_mag[WORD_W-2:0])))
        : (|fin_mag[MAG_W-1:WORD_W-1]);
    assign sgn_res = fin_neg ? (~fin_mag[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, 1'b1})
                             : fin_mag[WORD_W-1:0];

    always_comb
    begin
        fin_res = '0;
        fin_ovf = 1'b0;
        fin_dz  = 1'b0;
        case (op_reg)
            OP_MUL:
            begin
                fin_res = sgn_res;
                fin_ovf = sgn_ovf;
            end
            OP_DIV:
            begin
                if (dz_reg)
                begin
                    fin_dz = 1'b1;
                end
                else
                begin
                    fin_res = sgn_res;
                    fin_ovf = sgn_ovf;
                end
            end
            OP_CVT:
            begin
                if (cvt_exp == FLT_EXP_SPECIAL)
                begin
                    // NaN or infinity
                    fin_ovf = 1'b1;
                end
                else if ((cvt_exp == FLT_EXP_ZERO) || (cvt_sh <= SH_MIN))
                begin
                    // zero, subnormal or too small: leave zero
                    fin_ovf = 1'b0;
                end
                else if (cvt_sh > SH_MAX)
                begin
                    // far out of range: overflow with a zero result
                    fin_ovf = 1'b1;
                end
                else
                begin
                    fin_res = sgn_res;
                    fin_ovf = sgn_ovf;
                end
            end
            default:
            begin
                fin_res = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_NONE;
            a_reg         <= '0;
            neg_reg       <= 1'b0;
            dz_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
            ovf_reg       <= 1'b0;
            dz_out_reg    <= 1'b0;
        end
        else
        begin
            // drop the result once taken; in S_FIN the load below takes over
            if (out_valid_reg && rsp.ready && (state_reg != S_FIN))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg  <= op_in;
                        a_reg   <= req.operand_a;
                        neg_reg <= req.operand_a[WORD_W-1] ^ req.operand_b[WORD_W-1];
                        dz_reg  <= b_zero;
                        state_reg <= cmd.start ? S_RUN : S_FIN;
                    end
                end
                S_RUN:
                begin
                    if (stat.done)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    // hold until the result register is free
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        result_reg    <= fin_res;
                        ovf_reg       <= fin_ovf;
                        dz_out_reg    <= fin_dz;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result      = result_reg;
    assign rsp.overflow    = ovf_reg;
    assign rsp.div_by_zero = dz_out_reg;

endmodule

`default_nettype wire

// ----- rtl/core/fpmdc_checker.sv -----
// Port-level assertions for the fixed-point unit and their bind to the top level
`timescale 1ns / 1ps
`default_nettype none

module fpmdc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] result,
    input logic        overflow,
    input logic        div_by_zero
);

    // divide by zero always returns zero without overflow
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && div_by_zero) |-> ((result == 32'd0) && !overflow))
        else $error("div_by_zero result not clean");

    // the two flags never show together
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(overflow && div_by_zero))
        else $error("overflow and div_by_zero both set");

    // an accepted item keeps the block busy for the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready right after accept");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(result)
                                       && $stable(overflow) && $stable(div_by_zero)))
        else $error("stalled result changed");

endmodule

bind fixed_point_mul_div_convert fpmdc_checker u_fpmdc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .result      (rsp.result),
    .overflow    (rsp.overflow),
    .div_by_zero (rsp.div_by_zero)
);

`default_nettype wire
